// File: hdl/shs_pkg.sv
package shs_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int MAX_KEY_LEN = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int POS_W       = $clog2(MAX_KEY_LEN);
    localparam int LEN_W       = POS_W + 1;
    localparam int CNT_W       = 9;
    localparam int KB_DEPTH    = TABLE_SLOTS * MAX_KEY_LEN;
    localparam int KB_AW       = SLOT_W + POS_W;

    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic             was_present;
        logic             inserted;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } result_t;

endpackage

// File: hdl/shs_ram.sv
module shs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/string_hash_set_linear_probe.sv
// channel | dir | handshake             | payload
// s_axis  | in  | s_axis_tvalid/tready  | tdata {key_byte}, tuser {action}, tlast key_last
// m_axis  | out | m_axis_tvalid/tready  | tdata {was_present,inserted,status,entry_count}
// key bytes are taken one per cycle while the block waits for input; the hash step and the buffer write
// happen as each byte is accepted; on the last byte a sequencer probes the table: for each occupied slot
// it reads and checks the hash and length, and on a match reads and compares the key bytes one by one
// an insert then copies the key byte by byte from the key buffer into the slot key memory
// reset clears the slot valid flags and the count and sets the hash to its seed at once; no clearing pass
// the result waits in an output register; input is stalled until it is taken
module string_hash_set_linear_probe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic        s_axis_tuser,   // [0] action
    input  logic        s_axis_tlast,   // key_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] was_present, [1] inserted, [3:2] status,
                                        // [12:4] entry_count, [15:13] zero
);

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_HREAD = 3'd1;
    localparam logic [2:0] S_HCHK  = 3'd2;
    localparam logic [2:0] S_BREAD = 3'd3;
    localparam logic [2:0] S_BCHK  = 3'd4;
    localparam logic [2:0] S_CREAD = 3'd5;
    localparam logic [2:0] S_CWR   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam int TABLE_BITS = shs_pkg::TABLE_SLOTS;

    logic [2:0]                 state_reg, state_next;
    logic [63:0]                hash_reg, hash_next;
    logic [shs_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       ovf_reg, ovf_next;
    logic                       act_reg, act_next;
    logic [shs_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [shs_pkg::SLOT_W:0]   probes_reg, probes_next;
    logic [shs_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [shs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [TABLE_BITS-1:0]      taken_reg, taken_next;
    shs_pkg::result_t           res_reg, res_next;

    // key buffer
    logic                       kb_we;
    logic [shs_pkg::POS_W-1:0]  kb_waddr, kb_raddr;
    logic [7:0]                 kb_rdata;
    // slot hash and length
    logic                       sh_we;
    logic [63:0]                sh_rdata;
    logic [shs_pkg::LEN_W-1:0]  sl_rdata;
    // slot key bytes
    logic                       sb_we;
    logic [shs_pkg::KB_AW-1:0]  sb_waddr, sb_raddr;
    logic [7:0]                 sb_rdata;

    logic [63:0] hash_step;
    logic        in_xfer;
    logic        last_pos;

    shs_ram #(.WIDTH(8), .DEPTH(shs_pkg::MAX_KEY_LEN)) u_key_buf (
        .clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(s_axis_tdata),
        .raddr(kb_raddr), .rdata(kb_rdata));

    shs_ram #(.WIDTH(64), .DEPTH(shs_pkg::TABLE_SLOTS)) u_slot_hash (
        .clk(clk), .we(sh_we), .waddr(slot_reg), .wdata(hash_reg),
        .raddr(slot_reg), .rdata(sh_rdata));

    shs_ram #(.WIDTH(shs_pkg::LEN_W), .DEPTH(shs_pkg::TABLE_SLOTS)) u_slot_len (
        .clk(clk), .we(sh_we), .waddr(slot_reg), .wdata(len_reg),
        .raddr(slot_reg), .rdata(sl_rdata));

    shs_ram #(.WIDTH(8), .DEPTH(shs_pkg::KB_DEPTH)) u_slot_bytes (
        .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(kb_rdata),
        .raddr(sb_raddr), .rdata(sb_rdata));

    assign s_axis_tready = (state_reg == S_IN);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {3'b000, res_reg.entry_count, res_reg.status,
                            res_reg.inserted, res_reg.was_present};

    // h*33 + c as shift and add
    assign hash_step = (hash_reg << 5) + hash_reg + {56'd0, s_axis_tdata};

    assign kb_we    = in_xfer && !len_reg[shs_pkg::POS_W];
    assign kb_waddr = len_reg[shs_pkg::POS_W-1:0];
    assign kb_raddr = pos_reg;
    assign sb_raddr = {slot_reg, pos_reg};
    assign sb_waddr = {slot_reg, pos_reg};
    assign sb_we    = (state_reg == S_CWR);
    assign last_pos = ({1'b0, pos_reg} + 1'b1) == len_reg;

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        act_next    = act_reg;
        slot_next   = slot_reg;
        probes_next = probes_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        taken_next  = taken_reg;
        res_next    = res_reg;
        sh_we       = 1'b0;
        case (state_reg)
            S_IN:
            begin
                if (in_xfer)
                begin
                    hash_next = hash_step;
                    if (len_reg[shs_pkg::POS_W])
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        act_next    = s_axis_tuser;
                        slot_next   = hash_step[shs_pkg::SLOT_W-1:0];
                        probes_next = '0;
                        pos_next    = '0;
                        res_next    = '{1'b0, 1'b0, shs_pkg::ST_OK, count_reg};
                        if (ovf_reg || len_reg[shs_pkg::POS_W])
                        begin
                            res_next.status = shs_pkg::ST_LONG;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_HREAD;
                        end
                    end
                end
            end
            S_HREAD:
            begin
                // probe end: table walked fully or free slot
                if (probes_reg[shs_pkg::SLOT_W] || !taken_reg[slot_reg])
                begin
                    if (act_reg)
                    begin
                        if (count_reg >= shs_pkg::CNT_W'(shs_pkg::TABLE_SLOTS - 1)
                            || probes_reg[shs_pkg::SLOT_W])
                        begin
                            res_next.status = shs_pkg::ST_FULL;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            sh_we                = 1'b1;
                            taken_next[slot_reg] = 1'b1;
                            count_next           = count_reg + 1'b1;
                            res_next.inserted    = 1'b1;
                            res_next.entry_count = count_reg + 1'b1;
                            pos_next             = '0;
                            state_next           = S_CREAD;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_HCHK;
                end
            end
            S_HCHK:
            begin
                pos_next = '0;
                if (sh_rdata == hash_reg && sl_rdata == len_reg)
                begin
                    state_next = S_BREAD;
                end
                else
                begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    state_next  = S_HREAD;
                end
            end
            S_BREAD:
            begin
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (sb_rdata != kb_rdata)
                begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    state_next  = S_HREAD;
                end
                else if (last_pos)
                begin
                    res_next.was_present = 1'b1;
                    state_next           = S_OUT;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_BREAD;
                end
            end
            S_CREAD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                if (last_pos)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_CREAD;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    hash_next  = shs_pkg::HASH_SEED;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IN;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            hash_reg   <= shs_pkg::HASH_SEED;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            count_reg  <= '0;
            taken_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            count_reg  <= count_next;
            taken_reg  <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        pos_reg    <= pos_next;
        res_reg    <= res_next;
    end

endmodule

// File: dv/string_set_checker.sv
`timescale 1ns / 1ps

module string_set_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_results
);

    logic [7:0]        cur_key [shs_pkg::MAX_KEY_LEN];
    int                cur_len;
    logic [63:0]       cur_hash;
    logic              cur_long;
    logic              taken [shs_pkg::TABLE_SLOTS];
    logic [63:0]       s_hash [shs_pkg::TABLE_SLOTS];
    int                s_len [shs_pkg::TABLE_SLOTS];
    logic [7:0]        s_bytes [shs_pkg::TABLE_SLOTS][shs_pkg::MAX_KEY_LEN];
    int                n_stored;
    shs_pkg::result_t  expected_results [$];

    assign pending_results = expected_results.size();

    function automatic bit slot_holds_key(int slot);
        if (s_hash[slot] != cur_hash || s_len[slot] != cur_len)
            return 0;
        for (int i = 0; i < cur_len; i++)
            if (s_bytes[slot][i] != cur_key[i])
                return 0;
        return 1;
    endfunction

    // fold one key byte in; on the final byte run the set operation
    task automatic apply_key_byte(logic act, logic [7:0] b, logic fin);
        shs_pkg::result_t r;
        int      slot;
        int      free_slot;
        bit      has_free;
        bit      hit;
        cur_hash = cur_hash * 64'd33 + {56'd0, b};
        if (cur_len < shs_pkg::MAX_KEY_LEN)
        begin
            cur_key[cur_len] = b;
            cur_len++;
        end
        else
            cur_long = 1;
        if (!fin)
            return;
        r = '0;
        hit = 0;
        has_free = 0;
        free_slot = 0;
        if (cur_long)
            r.status = shs_pkg::ST_LONG;
        else
        begin
            slot = int'(cur_hash % shs_pkg::TABLE_SLOTS);
            for (int p = 0; p < shs_pkg::TABLE_SLOTS; p++)
            begin
                if (!taken[slot])
                begin
                    free_slot = slot;
                    has_free = 1;
                    break;
                end
                if (slot_holds_key(slot))
                begin
                    hit = 1;
                    break;
                end
                slot = (slot + 1) % shs_pkg::TABLE_SLOTS;
            end
            r.was_present = hit;
            if (act && !hit)
            begin
                if (n_stored >= shs_pkg::TABLE_SLOTS - 1 || !has_free)
                    r.status = shs_pkg::ST_FULL;
                else
                begin
                    taken[free_slot] = 1;
                    s_hash[free_slot] = cur_hash;
                    s_len[free_slot] = cur_len;
                    for (int i = 0; i < cur_len; i++)
                        s_bytes[free_slot][i] = cur_key[i];
                    n_stored++;
                    r.inserted = 1;
                end
            end
        end
        r.entry_count = n_stored[shs_pkg::CNT_W-1:0];
        expected_results.push_back(r);
        cur_len = 0;
        cur_hash = shs_pkg::HASH_SEED;
        cur_long = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shs_pkg::result_t want;
        shs_pkg::result_t got;
        if (!rst_n)
        begin
            cur_len = 0;
            cur_hash = shs_pkg::HASH_SEED;
            cur_long = 0;
            n_stored = 0;
            fail_count = 0;
            for (int i = 0; i < shs_pkg::TABLE_SLOTS; i++)
                taken[i] = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                // tdata carries the fields from bit 0 up
                got.was_present = m_axis_tdata[0];
                got.inserted    = m_axis_tdata[1];
                got.status      = m_axis_tdata[3:2];
                got.entry_count = m_axis_tdata[12:4];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want || m_axis_tdata[15:13] != 3'd0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected present=%0d ins=%0d st=%0d cnt=%0d,",
                                     want.was_present, want.inserted, want.status,
                                     want.entry_count,
                                     " got present=%0d ins=%0d st=%0d cnt=%0d pad=%0d",
                                     got.was_present, got.inserted, got.status,
                                     got.entry_count, m_axis_tdata[15:13]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_key_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
    end

endmodule

// File: dv/string_hash_set_linear_probe_test.sv
`timescale 1ns / 1ps

module string_hash_set_linear_probe_test;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] key_byte
    logic        s_axis_tuser;   // [0] action
    logic        s_axis_tlast;   // key_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [0] was_present, [1] inserted, [3:2] status, [12:4] count
    int          fail_count;
    int          pending_results;
    int          cycle_count;
    int          hold_off;       // receiver holds off while non-zero
    bit          stim_done;

    // keys reused so that lookups and repeat inserts hit stored entries
    typedef struct {
        int          len;
        logic [7:0]  bytes [shs_pkg::MAX_KEY_LEN + 8];
    } key_t;
    key_t key_pool [$];

    localparam int CYCLE_LIMIT = 3000000;

    string_hash_set_linear_probe dut (.*);

    string_set_checker checker_i (.*);

    initial clk = 0;
    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall pattern, overridden by the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 0;
        else if (hold_off > 0)
            m_axis_tready <= 0;
        else if ((cycle_count / 300) % 4 == 0)
            m_axis_tready <= 1;   // a stretch with no stalls
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
        if (hold_off > 0)
            hold_off <= hold_off - 1;

    // one transfer offered and held until accepted
    task automatic send_byte(logic act, logic [7:0] b, logic fin);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= act;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    // whole key; the action bit varies on non-final bytes, only the last one counts
    task automatic send_key(logic act, key_t k, bit bursty);
        for (int i = 0; i < k.len; i++)
        begin
            send_byte((i == k.len - 1) ? act : logic'($urandom_range(0, 1)),
                      k.bytes[i], i == k.len - 1);
            if (bursty && $urandom_range(0, 5) == 0)
                idle_gap();
        end
    endtask

    function automatic key_t random_key(int len);
        key_t k;
        k.len = len;
        for (int i = 0; i < len; i++)
            k.bytes[i] = $urandom_range(1, 255);
        return k;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        key_t k;
        int   n;
        int   pick;
        rst_n = 0;
        cycle_count = 0;
        hold_off = 0;
        stim_done = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        s_axis_tlast = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single byte extremes, lookup miss, insert, repeat insert, lookup hit
        k = random_key(1);
        k.bytes[0] = 8'hff;
        send_key(0, k, 0);
        send_key(1, k, 0);
        send_key(1, k, 0);
        send_key(0, k, 0);
        k.bytes[0] = 8'h01;
        send_key(1, k, 0);
        k.bytes[0] = 8'h00;   // nul handled as an ordinary character
        send_key(1, k, 0);
        // longest key that fits, then one byte over
        k = random_key(shs_pkg::MAX_KEY_LEN);
        send_key(1, k, 0);
        send_key(0, k, 0);
        k = random_key(shs_pkg::MAX_KEY_LEN + 1);
        send_key(1, k, 0);
        // colliding keys "Ab" / "BA": same hash and home slot, same length, different bytes
        k.len = 2; k.bytes[0] = "A"; k.bytes[1] = "b";
        send_key(1, k, 0);
        k.bytes[0] = "B"; k.bytes[1] = "A";
        send_key(0, k, 0);
        send_key(1, k, 0);
        send_key(0, k, 0);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off <= 400;
        for (int i = 0; i < 30; i++)
        begin
            k = random_key($urandom_range(1, 4));
            send_key($urandom_range(0, 1), k, 0);
        end
        drain();

        // random: mostly short keys, some reuse, occasional over-long or large keys
        n = 0;
        while (n < 400)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && key_pool.size() > 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (pick < 32)
                k = random_key($urandom_range(shs_pkg::MAX_KEY_LEN - 2,
                                              shs_pkg::MAX_KEY_LEN + 3));
            else
            begin
                k = random_key($urandom_range(1, 6));
                if (key_pool.size() < 64)
                    key_pool.push_back(k);
            end
            send_key($urandom_range(0, 2) != 0, k, 1);
            n += k.len;
            if ($urandom_range(0, 7) == 0)
                idle_gap();
            if ($urandom_range(0, 299) == 0)
                drain();
        end
        drain();

        // fill the table past capacity so full refusals show up, with repeat inserts of pooled keys between
        for (int i = 0; i < 300; i++)
        begin
            k = random_key($urandom_range(1, 3));
            send_key(1, k, 1);
            if (i % 10 == 0 && key_pool.size() > 0)
                send_key(1, key_pool[$urandom_range(0, key_pool.size() - 1)], 1);
        end
        drain();

        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
